// ===== rtl/core/tbo_pkg.sv =====
// ----------------------------------------------------------------------------
// tbo_pkg
// Shared types, widths and helpers for the triangle / box overlap classifier.
// ----------------------------------------------------------------------------
package tbo_pkg;

  localparam int CW     = 16;       // coordinate width
  localparam int DW     = CW + 1;   // coordinate difference
  localparam int PW     = 2 * DW;   // product of two differences
  localparam int XW     = PW + 1;   // difference of two products
  localparam int TW     = 8;        // tolerance register width
  localparam int CFG_AW = 3;        // byte address, one 32-bit register
  localparam int CFG_DW = 32;

  localparam logic [TW-1:0] TOL_RESET = TW'(1);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic [1:0]           verdict_t;

  localparam verdict_t V_OUTSIDE = 2'd0;
  localparam verdict_t V_INSIDE  = 2'd1;
  localparam verdict_t V_CROSS   = 2'd2;

  // register index 0 sits at byte address 0
  localparam logic REG_EDGE_TOL = 1'b0;

  // box side order used in all per-side vectors
  localparam int S_LEFT   = 0;
  localparam int S_RIGHT  = 1;
  localparam int S_BOTTOM = 2;
  localparam int S_TOP    = 3;

  function automatic diff_t sub_c(input coord_t a, input coord_t b);
    sub_c = diff_t'({a[CW-1], a}) - diff_t'({b[CW-1], b});
  endfunction

  // a - b > 0, exact
  function automatic logic pos_diff(input prod_t a, input prod_t b);
    logic signed [XW-1:0] d;
    d = {a[PW-1], a} - {b[PW-1], b};
    pos_diff = !d[XW-1] && (d != '0);
  endfunction

endpackage

// ===== rtl/core/tbo_in_if.sv =====
// ----------------------------------------------------------------------------
// tbo_in_if
// Input channel: one triangle and one box per transaction.
// ----------------------------------------------------------------------------
interface tbo_in_if;
  import tbo_pkg::*;

  logic   valid;
  logic   ready;
  coord_t tri_x0;
  coord_t tri_y0;
  coord_t tri_x1;
  coord_t tri_y1;
  coord_t tri_x2;
  coord_t tri_y2;
  coord_t box_left;
  coord_t box_right;
  coord_t box_bottom;
  coord_t box_top;

  modport source (
    output valid, tri_x0, tri_y0, tri_x1, tri_y1, tri_x2, tri_y2,
           box_left, box_right, box_bottom, box_top,
    input  ready
  );
  modport sink (
    input  valid, tri_x0, tri_y0, tri_x1, tri_y1, tri_x2, tri_y2,
           box_left, box_right, box_bottom, box_top,
    output ready
  );
endinterface

// ===== rtl/core/tbo_out_if.sv =====
// ----------------------------------------------------------------------------
// tbo_out_if
// Result channel: one verdict per transaction.
// ----------------------------------------------------------------------------
interface tbo_out_if;
  import tbo_pkg::*;

  logic     valid;
  logic     ready;
  verdict_t verdict;

  modport source (output valid, verdict, input ready);
  modport sink   (input valid, verdict, output ready);
endinterface

// ===== rtl/core/triangle_box_overlap_classifier.sv =====
// ----------------------------------------------------------------------------
// triangle_box_overlap_classifier
// Classifies a triangle against an axis-aligned box: outside, inside, crossing.
// ----------------------------------------------------------------------------
// One transaction per clock, unless the output register is full and not taken.
// The pipeline has three register stages: comparisons and coordinate
// differences, twelve 17x17 signed products (four per triangle edge), then the
// cross-product signs and verdict logic into the output register. The whole
// pipeline advances whenever the output register is empty or being taken, so
// in_ch.ready follows out_ch.ready combinationally. A vertex counts as inside
// when strictly within the box, or within edge_tolerance of exactly one side
// and strictly inside on the other three. A box wholly inside the triangle
// reports outside. edge_tolerance (byte address 0) must only change while the
// block is empty.
// ----------------------------------------------------------------------------
module triangle_box_overlap_classifier (
  input  logic                       clk,
  input  logic                       rst_n,
  tbo_in_if.sink                     in_ch,
  tbo_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tbo_pkg::CFG_AW-1:0] paddr,
  input  logic [tbo_pkg::CFG_DW-1:0] pwdata,
  output logic [tbo_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import tbo_pkg::*;

  // -------------------------------------------------------------------------
  // config register
  // -------------------------------------------------------------------------
  logic [TW-1:0] tol_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EDGE_TOL) ? CFG_DW'(tol_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_EDGE_TOL)) begin
      tol_r <= pwdata[TW-1:0];
    end
  end

  // -------------------------------------------------------------------------
  // pipeline control: global advance
  // -------------------------------------------------------------------------
  logic en;
  logic b_valid_r, c_valid_r, out_valid_r;
  verdict_t out_verdict_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.verdict = out_verdict_r;

  // -------------------------------------------------------------------------
  // stage A (comb): compares and differences straight off the input
  // -------------------------------------------------------------------------
  coord_t vx [3];
  coord_t vy [3];
  coord_t xl, xr, yb, yt;

  assign vx[0] = in_ch.tri_x0;  assign vy[0] = in_ch.tri_y0;
  assign vx[1] = in_ch.tri_x1;  assign vy[1] = in_ch.tri_y1;
  assign vx[2] = in_ch.tri_x2;  assign vy[2] = in_ch.tri_y2;
  assign xl = in_ch.box_left;
  assign xr = in_ch.box_right;
  assign yb = in_ch.box_bottom;
  assign yt = in_ch.box_top;

  logic [2:0]      a_vin;
  logic [2:0][3:0] a_lside;   // vertex left of each box side line
  logic [2:0][3:0] a_strad;   // edge strictly straddles each side
  logic [2:0][3:0] a_gt, a_lt;
  diff_t a_dxe [3], a_dye [3], a_dyb [3], a_dyt [3], a_dxl [3], a_dxr [3];

  always_comb begin
    diff_t hd, wd;
    logic  hpos, hneg, wpos, wneg;
    logic signed [DW:0] tol_s, dd;
    diff_t d [4];
    logic [3:0] nr;
    int e;
    hd = sub_c(yt, yb);
    wd = sub_c(xr, xl);
    hpos = !hd[DW-1] && (hd != '0);
    hneg = hd[DW-1];
    wpos = !wd[DW-1] && (wd != '0);
    wneg = wd[DW-1];
    tol_s = {{(DW+1-TW){1'b0}}, tol_r};
    for (int v = 0; v < 3; v++) begin
      d[S_LEFT]   = sub_c(vx[v], xl);
      d[S_RIGHT]  = sub_c(vx[v], xr);
      d[S_BOTTOM] = sub_c(vy[v], yb);
      d[S_TOP]    = sub_c(vy[v], yt);
      for (int s = 0; s < 4; s++) begin
        a_gt[v][s] = !d[s][DW-1] && (d[s] != '0);
        a_lt[v][s] = d[s][DW-1];
        dd = {d[s][DW-1], d[s]};
        nr[s] = (dd < tol_s) && (dd > -tol_s);
      end
      // strictly inside, or near one side and strictly in on the rest
      a_vin[v] =
        (a_gt[v][S_LEFT] && a_lt[v][S_RIGHT] && a_gt[v][S_BOTTOM] && a_lt[v][S_TOP]) ||
        (nr[S_LEFT]      && a_lt[v][S_RIGHT] && a_gt[v][S_BOTTOM] && a_lt[v][S_TOP]) ||
        (a_gt[v][S_LEFT] && nr[S_RIGHT]      && a_gt[v][S_BOTTOM] && a_lt[v][S_TOP]) ||
        (a_gt[v][S_LEFT] && a_lt[v][S_RIGHT] && nr[S_BOTTOM]      && a_lt[v][S_TOP]) ||
        (a_gt[v][S_LEFT] && a_lt[v][S_RIGHT] && a_gt[v][S_BOTTOM] && nr[S_TOP]);
      // side lines are axis-aligned: the cross product reduces to a sign test
      a_lside[v][S_LEFT]   = (a_gt[v][S_LEFT]   && hneg) || (a_lt[v][S_LEFT]   && hpos);
      a_lside[v][S_RIGHT]  = (a_gt[v][S_RIGHT]  && hneg) || (a_lt[v][S_RIGHT]  && hpos);
      a_lside[v][S_BOTTOM] = (a_gt[v][S_BOTTOM] && wpos) || (a_lt[v][S_BOTTOM] && wneg);
      a_lside[v][S_TOP]    = (a_gt[v][S_TOP]    && wpos) || (a_lt[v][S_TOP]    && wneg);
    end
    for (int k = 0; k < 3; k++) begin
      e = (k == 2) ? 0 : k + 1;
      for (int s = 0; s < 4; s++) begin
        a_strad[k][s] = (a_lt[k][s] && a_gt[e][s]) || (a_gt[k][s] && a_lt[e][s]);
      end
      a_dxe[k] = sub_c(vx[e], vx[k]);
      a_dye[k] = sub_c(vy[e], vy[k]);
      a_dyb[k] = sub_c(yb, vy[k]);
      a_dyt[k] = sub_c(yt, vy[k]);
      a_dxl[k] = sub_c(xl, vx[k]);
      a_dxr[k] = sub_c(xr, vx[k]);
    end
  end

  // -------------------------------------------------------------------------
  // stage B regs
  // -------------------------------------------------------------------------
  logic [2:0]      b_vin_r;
  logic [2:0][3:0] b_lside_r, b_strad_r;
  diff_t b_dxe_r [3], b_dye_r [3], b_dyb_r [3], b_dyt_r [3], b_dxl_r [3], b_dxr_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_vin_r   <= a_vin;
      b_lside_r <= a_lside;
      b_strad_r <= a_strad;
      b_dxe_r   <= a_dxe;
      b_dye_r   <= a_dye;
      b_dyb_r   <= a_dyb;
      b_dyt_r   <= a_dyt;
      b_dxl_r   <= a_dxl;
      b_dxr_r   <= a_dxr;
    end
  end

  // -------------------------------------------------------------------------
  // stage C: edge-vs-corner product terms
  // -------------------------------------------------------------------------
  logic [2:0]      c_vin_r;
  logic [2:0][3:0] c_lside_r, c_strad_r;
  prod_t c_pyb_r [3], c_pyt_r [3], c_pxl_r [3], c_pxr_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_vin_r   <= b_vin_r;
      c_lside_r <= b_lside_r;
      c_strad_r <= b_strad_r;
      for (int k = 0; k < 3; k++) begin
        c_pyb_r[k] <= b_dxe_r[k] * b_dyb_r[k];
        c_pyt_r[k] <= b_dxe_r[k] * b_dyt_r[k];
        c_pxl_r[k] <= b_dye_r[k] * b_dxl_r[k];
        c_pxr_r[k] <= b_dye_r[k] * b_dxr_r[k];
      end
    end
  end

  // -------------------------------------------------------------------------
  // stage D (comb): corner signs, crossing counts, verdict
  // -------------------------------------------------------------------------
  verdict_t verdict_nxt;

  always_comb begin
    logic lbl, ltl, lbr, ltr;
    logic [3:0] cr;
    logic [2:0] cnt;
    logic [2:0] touch;
    logic si, ei;
    int e;
    for (int k = 0; k < 3; k++) begin
      e   = (k == 2) ? 0 : k + 1;
      lbl = pos_diff(c_pyb_r[k], c_pxl_r[k]);
      ltl = pos_diff(c_pyt_r[k], c_pxl_r[k]);
      lbr = pos_diff(c_pyb_r[k], c_pxr_r[k]);
      ltr = pos_diff(c_pyt_r[k], c_pxr_r[k]);
      cr[S_LEFT]   = c_strad_r[k][S_LEFT] &&
                     (c_lside_r[k][S_LEFT] != c_lside_r[e][S_LEFT]) && (lbl != ltl);
      cr[S_RIGHT]  = c_strad_r[k][S_RIGHT] &&
                     (c_lside_r[k][S_RIGHT] != c_lside_r[e][S_RIGHT]) && (lbr != ltr);
      cr[S_BOTTOM] = c_strad_r[k][S_BOTTOM] &&
                     (c_lside_r[k][S_BOTTOM] != c_lside_r[e][S_BOTTOM]) && (lbl != lbr);
      cr[S_TOP]    = c_strad_r[k][S_TOP] &&
                     (c_lside_r[k][S_TOP] != c_lside_r[e][S_TOP]) && (ltl != ltr);
      cnt = 3'(cr[0]) + 3'(cr[1]) + 3'(cr[2]) + 3'(cr[3]);
      si  = c_vin_r[k];
      ei  = c_vin_r[e];
      // single crossing needs one end inside; two or more always touch
      touch[k] = (si && ei) || (cnt >= 3'd2) || ((cnt != 3'd0) && (si || ei));
    end
    if (&c_vin_r)      verdict_nxt = V_INSIDE;
    else if (|touch)   verdict_nxt = V_CROSS;
    else               verdict_nxt = V_OUTSIDE;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_verdict_r <= verdict_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> b_valid_r)
    else $error("accepted transaction did not enter stage B");

  a_no_code3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_verdict_r != 2'd3))
    else $error("illegal verdict code");

  a_inside_path: assert property (@(posedge clk) disable iff (!rst_n)
    (en && c_valid_r && (&c_vin_r)) |=> (out_valid_r && out_verdict_r == V_INSIDE))
    else $error("all vertices inside but verdict not inside");

  a_stall_holds_b: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && b_valid_r) |=> b_valid_r)
    else $error("stage B lost a transaction during stall");

endmodule

// ===== verif/tb_triangle_box_overlap_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_box_overlap_classifier
// Self-checking bench: directed and random triangle/box pairs, several
// tolerance settings, random gaps and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_triangle_box_overlap_classifier;
  import tbo_pkg::*;

  // Coordinate pair used by the verdict predictor, in full-width integers.
  typedef struct {
    longint x;
    longint y;
  } point_t;

  // One triangle/box pair as sent on the input channel.
  typedef struct packed {
    coord_t x0, y0, x1, y1, x2, y2, bl, br, bb, bt;
  } pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  tbo_in_if  in_ch ();
  tbo_out_if out_ch ();

  triangle_box_overlap_classifier u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #1 clk = ~clk;

  // Local copy of the tolerance register, tracked on each write.
  longint   tol_model = 1;
  verdict_t verdict_q[$];     // expected verdicts, oldest first
  int       mismatch_cnt = 0;
  int       idle_cycles = 0;  // cycles with no transfer and no config access
  bit       hold_out = 1'b0;  // forces the receiver to stall
  bit       bursty_out = 1'b1;

  // ---------------------------------------------------------------------------
  // Predictor: exact integer geometry. 64-bit longint is plenty, since the
  // products of 17-bit differences fit in 34 bits.
  // ---------------------------------------------------------------------------
  function automatic bit left_of(point_t p1, point_t p2, point_t v);
    return (p2.x - p1.x) * (v.y - p1.y) - (v.x - p1.x) * (p2.y - p1.y) > 0;
  endfunction

  function automatic bit seg_cross(point_t s, point_t e, point_t q1, point_t q2);
    if (left_of(q1, q2, s) == left_of(q1, q2, e)) return 1'b0;
    if (left_of(s, e, q1) == left_of(s, e, q2)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit near_side(longint a, longint b);
    longint d;
    d = a - b;
    if (d < 0) d = -d;
    return d < tol_model;
  endfunction

  // Strictly inside, or within the tolerance band of one side.
  function automatic bit vtx_in(point_t v, longint xl, longint xr, longint yb, longint yt);
    bit gx, lx, gy, ly;
    gx = v.x > xl; lx = v.x < xr; gy = v.y > yb; ly = v.y < yt;
    return (gx && lx && gy && ly) || (near_side(v.x, xl) && lx && gy && ly) ||
           (gx && near_side(v.x, xr) && gy && ly) ||
           (gx && lx && near_side(v.y, yb) && ly) ||
           (gx && lx && gy && near_side(v.y, yt));
  endfunction

  function automatic bit straddles(longint a, longint b, longint c);
    return (a < c && b > c) || (a > c && b < c);
  endfunction

  function automatic bit edge_hits_box(point_t s, point_t e, longint xl, longint xr,
                                       longint yb, longint yt);
    bit si, ei;
    int hits;
    point_t bl, tl, br, tr;
    si = vtx_in(s, xl, xr, yb, yt);
    ei = vtx_in(e, xl, xr, yb, yt);
    bl = '{xl, yb}; tl = '{xl, yt}; br = '{xr, yb}; tr = '{xr, yt};
    hits = 0;
    if (si && ei) return 1'b1;
    if (straddles(s.x, e.x, xl) && seg_cross(s, e, bl, tl)) hits++;
    if (straddles(s.x, e.x, xr) && seg_cross(s, e, br, tr)) hits++;
    if (straddles(s.y, e.y, yb) && seg_cross(s, e, bl, br)) hits++;
    if (straddles(s.y, e.y, yt) && seg_cross(s, e, tl, tr)) hits++;
    if (hits == 0) return 1'b0;
    if (hits == 1) return si || ei;
    return 1'b1;
  endfunction

  function automatic verdict_t classify(pair_t p);
    point_t a, b, c;
    longint xl, xr, yb, yt;
    a = '{longint'(p.x0), longint'(p.y0)};
    b = '{longint'(p.x1), longint'(p.y1)};
    c = '{longint'(p.x2), longint'(p.y2)};
    xl = p.bl; xr = p.br; yb = p.bb; yt = p.bt;
    if (vtx_in(a, xl, xr, yb, yt) && vtx_in(b, xl, xr, yb, yt) &&
        vtx_in(c, xl, xr, yb, yt))
      return V_INSIDE;
    if (edge_hits_box(a, b, xl, xr, yb, yt) || edge_hits_box(b, c, xl, xr, yb, yt) ||
        edge_hits_box(c, a, xl, xr, yb, yt))
      return V_CROSS;
    return V_OUTSIDE;
  endfunction

  // ---------------------------------------------------------------------------
  // Gap lengths: mostly zero or short, now and then long.
  // ---------------------------------------------------------------------------
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic report(string what, verdict_t got, verdict_t want);
    mismatch_cnt++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // Send one transaction and record its predicted verdict on acceptance.
  // Valid stays high after acceptance; it drops only for a gap or a drain.
  task automatic send_pair(pair_t p, bit with_gap = 1'b1);
    int g;
    g = with_gap ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.tri_x0     <= p.x0; in_ch.tri_y0 <= p.y0;
    in_ch.tri_x1     <= p.x1; in_ch.tri_y1 <= p.y1;
    in_ch.tri_x2     <= p.x2; in_ch.tri_y2 <= p.y2;
    in_ch.box_left   <= p.bl; in_ch.box_right  <= p.br;
    in_ch.box_bottom <= p.bb; in_ch.box_top    <= p.bt;
    do @(posedge clk); while (!in_ch.ready);
    verdict_q.push_back(classify(p));
  endtask

  // Wait for the pipeline to drain, plus its latency, before a register write.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // APB write with setup and access phases, then a readback check.
  task automatic write_tol(logic [7:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_AW'({REG_EDGE_TOL, 2'b00}); pwdata <= {$urandom} & ~32'hFF | value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tol_model = value;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== value) report("tolerance readback", prdata[1:0], value[1:0]);
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  // Random coordinate with a bias to the extremes.
  function automatic coord_t rnd_coord();
    case ($urandom_range(9))
      0: return coord_t'(16'sh8000);
      1: return coord_t'(16'sh7FFF);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Well-formed box with a random center and size, and a triangle whose
  // vertices sit near, inside or around it so that every verdict occurs.
  function automatic pair_t rnd_pair(int span);
    pair_t p;
    int cx, cy, w, h, r;
    coord_t v[6];
    cx = $urandom_range(2 * span) - span;
    cy = $urandom_range(2 * span) - span;
    w  = $urandom_range(span / 2 + 1, 1);
    h  = $urandom_range(span / 2 + 1, 1);
    p.bl = coord_t'(cx - w); p.br = coord_t'(cx + w);
    p.bb = coord_t'(cy - h); p.bt = coord_t'(cy + h);
    r = $urandom_range(3);
    for (int i = 0; i < 6; i++) begin
      int c, ext;
      c = (i % 2) ? cy : cx;
      ext = (i % 2) ? h : w;
      case (r)
        0: v[i] = coord_t'(c + int'($urandom_range(2 * ext)) - ext);   // near box
        1: v[i] = coord_t'(c + int'($urandom_range(6 * ext)) - 3 * ext);
        2: v[i] = coord_t'(c + (($urandom_range(1)) ? ext : -ext)
                           + int'($urandom_range(4)) - 2);               // on sides
        default: v[i] = coord_t'(c + int'($urandom_range(2 * ext - 2)) - ext + 1);
      endcase
    end
    {p.x0, p.y0, p.x1, p.y1, p.x2, p.y2} = {v[0], v[1], v[2], v[3], v[4], v[5]};
    return p;
  endfunction

  function automatic pair_t mk(int x0, int y0, int x1, int y1, int x2, int y2,
                               int l, int r, int b, int t);
    pair_t p;
    p = '{coord_t'(x0), coord_t'(y0), coord_t'(x1), coord_t'(y1), coord_t'(x2),
          coord_t'(y2), coord_t'(l), coord_t'(r), coord_t'(b), coord_t'(t)};
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, optional long hold-off, and result checking.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          report("unexpected verdict", out_ch.verdict, V_OUTSIDE);
        end else begin
          verdict_t want;
          want = verdict_q.pop_front();
          if (out_ch.verdict !== want) report("verdict", out_ch.verdict, want);
        end
      end
      if (hold_out)
        out_ch.ready <= 1'b0;
      else if (!bursty_out)
        out_ch.ready <= 1'b1;
      else
        out_ch.ready <= ($urandom_range(99) < 70);
    end
  end

  // Watchdog on cycles with no transaction on either channel and no config access.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    send_pair(mk(1, 1, 2, 2, 3, 1, 0, 10, 0, 10));               // fully inside
    send_pair(mk(20, 20, 30, 20, 25, 30, 0, 10, 0, 10));         // far outside
    send_pair(mk(-5, 5, 5, 5, 5, 6, 0, 10, 0, 10));              // one crossing
    send_pair(mk(-5, 5, 15, 5, 15, 6, 0, 10, 0, 10));            // passes through
    send_pair(mk(-100, -100, 100, -100, 0, 100, -1, 1, -1, 1));  // box in triangle
    send_pair(mk(0, 5, 5, 5, 5, 6, 0, 10, 0, 10));               // vertex on side
    send_pair(mk(-5, 0, 15, 0, 5, -5, 0, 10, 0, 10));            // collinear with side
    send_pair(mk(3, 3, 3, 3, 3, 3, 0, 10, 0, 10));               // degenerate point
    send_pair(mk(-5, 5, -5, 5, 5, 5, 0, 10, 0, 10));             // repeated vertices
    send_pair(mk(1, 1, 2, 2, 3, 1, 10, 0, 10, 0));               // inverted box
    send_pair(mk(-32768, -32768, 32767, 32767, -32768, 32767,
                 -32768, 32767, -32768, 32767));                 // extremes
    send_pair(mk(32767, -32768, -32768, 32767, 32767, 32767,
                 -1, 0, -1, 0));
    send_pair(mk(-32768, 0, 32767, 0, 0, 1, -32767, 32766, -1, 1));
    send_pair(mk(-5, 15, 5, 5, 15, -5, 0, 10, 0, 10));           // corner-touching
    send_pair(mk(1, 1, 1, 1, 1, 1, 0, 2, 0, 2));
  endtask

  task automatic test_tolerance(logic [7:0] tol);
    drain();
    write_tol(tol);
    send_pair(mk(0, 5, 1, 5, 2, 6, 0, 10, 0, 10));               // on left side
    send_pair(mk(10 + tol / 2, 5, 9, 5, 8, 6, 0, 10, 0, 10));    // in band on right
    send_pair(mk(5, tol, 5, 9, 6, 9, 0, 10, 0, 10));
    send_pair(mk(0, 0, 1, 1, 2, 1, 0, 10, 0, 10));               // corner, two sides
    for (int i = 0; i < 40; i++) send_pair(rnd_pair(20));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      pair_t p;
      case ($urandom_range(9))
        0: p = '{rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                 rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
        1: p = rnd_pair(30000);
        2, 3: p = rnd_pair(300);
        default: p = rnd_pair(40);
      endcase
      send_pair(p, i % 100 >= 30);   // stretches with no input gaps
    end
  endtask

  // Receiver holds off while the sender keeps offering back to back.
  task automatic test_backpressure();
    fork
      begin
        hold_out = 1'b1;
        repeat (60) @(posedge clk);
        hold_out = 1'b0;
      end
      for (int i = 0; i < 30; i++) send_pair(rnd_pair(40), 1'b0);
    join
  endtask

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.tri_x0, in_ch.tri_y0, in_ch.tri_x1, in_ch.tri_y1, in_ch.tri_x2,
     in_ch.tri_y2, in_ch.box_left, in_ch.box_right, in_ch.box_bottom,
     in_ch.box_top} = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_tolerance(8'd0);
    test_tolerance(8'd255);
    test_tolerance(8'd3);
    test_backpressure();
    bursty_out = 1'b0;
    test_random(200);
    bursty_out = 1'b1;
    drain();
    write_tol(8'd1);
    test_random(400);
    drain();
    write_tol(8'd17);
    test_random(100);
    drain();
    if (mismatch_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tbo_pkg.sv
rtl/core/tbo_in_if.sv
rtl/core/tbo_out_if.sv
rtl/core/triangle_box_overlap_classifier.sv
verif/tb_triangle_box_overlap_classifier.sv
